FILE: hw/rtl/sacmc_pkg.sv
`default_nettype none

package sacmc_pkg;

  localparam int MAX_ENTRIES = 512;
  localparam int MAX_WAYS    = 8;

  localparam int ADDR_W  = 31;
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int WAYC_W  = $clog2(MAX_WAYS + 1);
  localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int PTR_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LINE_W  = ADDR_W + 1;

  // Remainder unit: a 32-bit dividend retired four quotient bits per cycle.
  localparam int DIV_W     = 32;
  localparam int DIV_STEPS = 4;
  localparam int DIV_CYC   = DIV_W / DIV_STEPS;
  localparam int DCNT_W    = $clog2(DIV_CYC);

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic REG_ENTRY_COUNT = 1'b0;
  localparam logic REG_WAY_COUNT   = 1'b1;

  typedef enum logic [1:0] {
    OC_HIT        = 2'd0,
    OC_COMPULSORY = 2'd1,
    OC_CAPACITY   = 2'd2,
    OC_CONFLICT   = 2'd3
  } outcome_t;

  typedef enum logic [3:0] {
    ST_GEO_START,
    ST_GEO_WAIT,
    ST_SWEEP,
    ST_IDLE,
    ST_DIV,
    ST_PROBE_RD,
    ST_PROBE_CMP,
    ST_FILL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic div_start;
    logic div_geo;
    logic load_geo;
    logic sweep;
    logic load_set;
    logic probe_rd;
    logic probe_cmp;
    logic fill;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sweep_last;
    logic hit;
    logic last_way;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sacmc_ram.sv
`default_nettype none

module sacmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hw/rtl/sacmc_div.sv
`default_nettype none

module sacmc_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [sacmc_pkg::DIV_W-1:0]    dividend,
  input  logic [sacmc_pkg::CNT_W-1:0]    divisor,
  output logic                           done,
  output logic [sacmc_pkg::DIV_W-1:0]    quotient,
  output logic [sacmc_pkg::CNT_W-1:0]    remainder
);

  import sacmc_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]  dvd_r, dvd_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  dvs_r;

  // Restoring division: the dividend register shifts out its top bit and
  // takes the quotient bit in at the bottom.
  always_comb begin
    logic [CNT_W:0]   rx;
    logic [DIV_W-1:0] d;
    logic [CNT_W-1:0] r;
    d = dvd_r;
    r = rem_r;
    for (int i = 0; i < DIV_STEPS; i++) begin
      rx = {r, d[DIV_W-1]};
      d  = {d[DIV_W-2:0], 1'b0};
      if (rx >= {1'b0, dvs_r}) begin
        rx   = rx - {1'b0, dvs_r};
        d[0] = 1'b1;
      end
      r = rx[CNT_W-1:0];
    end
    dvd_nxt = d;
    rem_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(DIV_CYC - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

FILE: hw/rtl/sacmc_dp.sv
`default_nettype none

module sacmc_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sacmc_pkg::ctrl_cmd_t            cmd,
  output sacmc_pkg::dp_sts_t              sts,
  input  logic [sacmc_pkg::CNT_W-1:0]     entry_count,
  input  logic [sacmc_pkg::WAYC_W-1:0]    way_count,
  input  logic [sacmc_pkg::ADDR_W-1:0]    in_ref_address,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_outcome
);

  import sacmc_pkg::*;

  // Geometry and fill tracking.
  logic [CNT_W-1:0]  sets_r;
  logic [WAYC_W-1:0] ways_r;
  logic [CNT_W-1:0]  cap_r;
  logic [CNT_W-1:0]  filled_r, filled_nxt;
  logic [IDX_W-1:0]  clr_idx_r;

  // Per-reference state.
  logic [ADDR_W-1:0] addr_r;
  logic [IDX_W-1:0]  set_r;
  logic [IDX_W-1:0]  slot_r;
  logic [PTR_W-1:0]  way_idx_r;
  logic [IDX_W-1:0]  victim_slot_r;
  logic              victim_empty_r;
  outcome_t          result_r;

  logic              out_valid_r;
  outcome_t          out_outcome_r;

  logic [CNT_W-1:0]  eff_e;
  logic [WAYC_W-1:0] eff_w;
  logic [DIV_W-1:0]  div_dvd;
  logic [CNT_W-1:0]  div_dvs;
  logic              div_done;
  logic [DIV_W-1:0]  div_quo;
  logic [CNT_W-1:0]  div_rem;

  logic [LINE_W-1:0] line_rdata;
  logic [PTR_W-1:0]  ptr_rdata;
  logic              st_we, pt_we;
  logic [IDX_W-1:0]  st_waddr, pt_waddr;
  logic [LINE_W-1:0] st_wdata;
  logic [PTR_W-1:0]  pt_wdata;
  logic [WAYC_W-1:0] ptr_inc;
  logic [PTR_W-1:0]  ptr_next;
  logic              hit;
  logic              last_way;
  logic [CNT_W-1:0]  geo_sets;
  logic [CNT_W+WAYC_W-1:0] geo_cap;

  // Clamp the configured geometry so at least one set always exists.
  always_comb begin
    eff_e = entry_count;
    if (entry_count == '0) begin
      eff_e = CNT_W'(1);
    end else if (entry_count > CNT_W'(MAX_ENTRIES)) begin
      eff_e = CNT_W'(MAX_ENTRIES);
    end
    eff_w = way_count;
    if (way_count == '0) begin
      eff_w = WAYC_W'(1);
    end else if (way_count > WAYC_W'(MAX_WAYS)) begin
      eff_w = WAYC_W'(MAX_WAYS);
    end
    if (CNT_W'(eff_w) > eff_e) begin
      eff_w = eff_e[WAYC_W-1:0];
    end
  end

  assign div_dvd = cmd.div_geo ? DIV_W'(eff_e) : DIV_W'(in_ref_address);
  assign div_dvs = cmd.div_geo ? CNT_W'(eff_w) : sets_r;

  sacmc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign geo_sets = div_quo[CNT_W-1:0];
  assign geo_cap  = geo_sets * ways_r;

  assign hit      = line_rdata[LINE_W-1] && (line_rdata[ADDR_W-1:0] == addr_r);
  assign last_way = (WAYC_W'(way_idx_r) + WAYC_W'(1)) == ways_r;
  assign ptr_inc  = WAYC_W'(ptr_rdata) + WAYC_W'(1);
  assign ptr_next = (ptr_inc == ways_r) ? '0 : ptr_inc[PTR_W-1:0];
  assign filled_nxt = filled_r + CNT_W'(victim_empty_r);

  // The clearing sweep and the miss fill share each memory's write port.
  assign st_we    = cmd.sweep | cmd.fill;
  assign st_waddr = cmd.sweep ? clr_idx_r : victim_slot_r;
  assign st_wdata = cmd.sweep ? '0 : {1'b1, addr_r};
  assign pt_we    = cmd.sweep | cmd.fill;
  assign pt_waddr = cmd.sweep ? clr_idx_r : set_r;
  assign pt_wdata = cmd.sweep ? '0 : ptr_next;

  sacmc_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_ENTRIES)
  ) u_line_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (cmd.probe_rd),
    .raddr (slot_r),
    .rdata (line_rdata)
  );

  sacmc_ram #(
    .WIDTH (PTR_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ptr_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .re    (cmd.probe_rd),
    .raddr (set_r),
    .rdata (ptr_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_geo) begin
        filled_r <= '0;
      end else if (cmd.fill) begin
        filled_r <= filled_nxt;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start && cmd.div_geo) begin
      ways_r <= eff_w;
    end
    if (cmd.load_geo) begin
      sets_r    <= geo_sets;
      cap_r     <= geo_cap[CNT_W-1:0];
      clr_idx_r <= '0;
    end
    if (cmd.sweep) begin
      clr_idx_r <= clr_idx_r + 1'b1;
    end
    if (cmd.div_start && !cmd.div_geo) begin
      addr_r <= in_ref_address;
    end
    if (cmd.load_set) begin
      set_r     <= div_rem[IDX_W-1:0];
      slot_r    <= div_rem[IDX_W-1:0];
      way_idx_r <= '0;
    end
    if (cmd.probe_cmp) begin
      // The way the round-robin pointer names is the victim on a miss.
      if (way_idx_r == ptr_rdata) begin
        victim_slot_r  <= slot_r;
        victim_empty_r <= !line_rdata[LINE_W-1];
      end
      if (hit) begin
        result_r <= OC_HIT;
      end else if (!last_way) begin
        slot_r    <= IDX_W'(CNT_W'(slot_r) + sets_r);
        way_idx_r <= way_idx_r + 1'b1;
      end
    end
    if (cmd.fill) begin
      if (filled_nxt >= cap_r) begin
        result_r <= OC_CAPACITY;
      end else if (victim_empty_r) begin
        result_r <= OC_COMPULSORY;
      end else begin
        result_r <= OC_CONFLICT;
      end
    end
    if (cmd.emit) begin
      out_outcome_r <= result_r;
    end
  end

  assign sts.div_done   = div_done;
  assign sts.sweep_last = (clr_idx_r == IDX_W'(MAX_ENTRIES - 1));
  assign sts.hit        = hit;
  assign sts.last_way   = last_way;
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid   = out_valid_r;
  assign out_outcome = out_outcome_r;

endmodule

`default_nettype wire

FILE: hw/rtl/sacmc_ctrl.sv
`default_nettype none

module sacmc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sacmc_pkg::dp_sts_t   sts,
  output sacmc_pkg::ctrl_cmd_t cmd
);

  import sacmc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_GEO_START;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (cfg_wr) begin
      // A register write rebuilds the geometry and clears the store.
      state_nxt = ST_GEO_START;
    end else begin
      unique case (state_r)
        ST_GEO_START: state_nxt = ST_GEO_WAIT;
        ST_GEO_WAIT: begin
          if (sts.div_done) state_nxt = ST_SWEEP;
        end
        ST_SWEEP: begin
          if (sts.sweep_last) state_nxt = ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid) state_nxt = ST_DIV;
        end
        ST_DIV: begin
          if (sts.div_done) state_nxt = ST_PROBE_RD;
        end
        ST_PROBE_RD: state_nxt = ST_PROBE_CMP;
        ST_PROBE_CMP: begin
          priority if (sts.hit) begin
            state_nxt = ST_EMIT;
          end else if (sts.last_way) begin
            state_nxt = ST_FILL;
          end else begin
            state_nxt = ST_PROBE_RD;
          end
        end
        ST_FILL: state_nxt = ST_EMIT;
        ST_EMIT: begin
          if (sts.out_free) state_nxt = ST_IDLE;
        end
        default: state_nxt = ST_GEO_START;
      endcase
    end
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_GEO_START: begin
        cmd.div_start = 1'b1;
        cmd.div_geo   = 1'b1;
      end
      ST_GEO_WAIT: cmd.load_geo = sts.div_done;
      ST_SWEEP:    cmd.sweep = 1'b1;
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.div_start = in_valid;
      end
      ST_DIV:       cmd.load_set = sts.div_done;
      ST_PROBE_RD:  cmd.probe_rd = 1'b1;
      ST_PROBE_CMP: cmd.probe_cmp = 1'b1;
      ST_FILL:      cmd.fill = 1'b1;
      ST_EMIT:      cmd.emit = sts.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/set_assoc_cache_miss_classifier_top.sv
`default_nettype none

// Channel   Direction  Handshake           Beat contents
// in_       input      in_valid/in_stall   in_ref_address (31 bits)
// out_      output     out_valid/out_stall out_outcome (2 bits)
// APB       input      psel/penable/pready entry_count at 0x0, way_count at 0x4
//
// A miss runs from accept to result through the set remainder, a read and a
// compare for each way probed, one fill and the output load. A hit in way k
// ends at the compare of way k and skips the fill. The next beat can be taken
// in the cycle after the result is loaded. After reset and after every register
// write the geometry is rebuilt and all 512 entries cleared while in_stall holds.
// A result held by out_stall does not block the next beat, only its result.

module set_assoc_cache_miss_classifier_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [sacmc_pkg::ADDR_W-1:0]     in_ref_address,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_outcome,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sacmc_pkg::APB_AW-1:0]     paddr,
  input  logic [sacmc_pkg::APB_DW-1:0]     pwdata,
  output logic [sacmc_pkg::APB_DW-1:0]     prdata,
  output logic                             pready
);

  import sacmc_pkg::*;

  logic [CNT_W-1:0]  entry_count_r;
  logic [WAYC_W-1:0] way_count_r;
  logic              cfg_wr;
  ctrl_cmd_t         cmd;
  dp_sts_t           sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= CNT_W'(MAX_ENTRIES);
      way_count_r   <= WAYC_W'(4);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ENTRY_COUNT: entry_count_r <= pwdata[CNT_W-1:0];
        REG_WAY_COUNT:   way_count_r   <= pwdata[WAYC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ENTRY_COUNT: prdata = APB_DW'(entry_count_r);
      REG_WAY_COUNT:   prdata = APB_DW'(way_count_r);
      default:         prdata = '0;
    endcase
  end

  sacmc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_wr),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sacmc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .entry_count    (entry_count_r),
    .way_count      (way_count_r),
    .in_ref_address (in_ref_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_outcome    (out_outcome)
  );

endmodule

`default_nettype wire

FILE: sim/set_assoc_cache_miss_classifier_top_test.sv
module set_assoc_cache_miss_classifier_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sacmc_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 40;

  typedef enum logic {
    ROW_REF,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic       reg_idx;
    logic [31:0] value;
    logic       typed;
    outcome_t   want;
  } stim_row_t;

  localparam int DIR_ROWS = 33;

  // Directed rows: extremes of the address, clamping of both registers, a
  // single-entry cache, a direct-mapped cache, a fully associative cache and
  // an entry count that leaves unused entries.
  stim_row_t dir_table [DIR_ROWS] = '{
    '{ROW_REF, 1'b0, 32'd0,          1'b1, OC_COMPULSORY},
    '{ROW_REF, 1'b0, 32'd0,          1'b1, OC_HIT},
    '{ROW_REF, 1'b0, 32'h7FFF_FFFF,  1'b1, OC_COMPULSORY},
    '{ROW_REF, 1'b0, 32'h7FFF_FFFF,  1'b1, OC_HIT},
    '{ROW_REF, 1'b0, 32'd128,        1'b1, OC_COMPULSORY},
    '{ROW_CFG, REG_ENTRY_COUNT, 32'd0, 1'b0, OC_HIT},
    '{ROW_REF, 1'b0, 32'd5,          1'b1, OC_CAPACITY},
    '{ROW_REF, 1'b0, 32'd5,          1'b1, OC_HIT},
    '{ROW_REF, 1'b0, 32'd6,          1'b1, OC_CAPACITY},
    '{ROW_CFG, REG_ENTRY_COUNT, 32'd1023, 1'b0, OC_HIT},
    '{ROW_CFG, REG_WAY_COUNT, 32'd0, 1'b0, OC_HIT},
    '{ROW_REF, 1'b0, 32'd3,          1'b1, OC_COMPULSORY},
    '{ROW_REF, 1'b0, 32'd515,        1'b1, OC_CONFLICT},
    '{ROW_REF, 1'b0, 32'd3,          1'b1, OC_CONFLICT},
    '{ROW_CFG, REG_WAY_COUNT, 32'd15, 1'b0, OC_HIT},
    '{ROW_CFG, REG_ENTRY_COUNT, 32'd8, 1'b0, OC_HIT},
    '{ROW_REF, 1'b0, 32'd0,          1'b1, OC_COMPULSORY},
    '{ROW_REF, 1'b0, 32'd1,          1'b1, OC_COMPULSORY},
    '{ROW_REF, 1'b0, 32'd2,          1'b1, OC_COMPULSORY},
    '{ROW_REF, 1'b0, 32'd3,          1'b1, OC_COMPULSORY},
    '{ROW_REF, 1'b0, 32'd4,          1'b1, OC_COMPULSORY},
    '{ROW_REF, 1'b0, 32'd5,          1'b1, OC_COMPULSORY},
    '{ROW_REF, 1'b0, 32'd6,          1'b1, OC_COMPULSORY},
    '{ROW_REF, 1'b0, 32'd7,          1'b1, OC_CAPACITY},
    '{ROW_REF, 1'b0, 32'd8,          1'b1, OC_CAPACITY},
    '{ROW_REF, 1'b0, 32'd1,          1'b1, OC_HIT},
    '{ROW_CFG, REG_ENTRY_COUNT, 32'd7, 1'b0, OC_HIT},
    '{ROW_CFG, REG_WAY_COUNT, 32'd3, 1'b0, OC_HIT},
    '{ROW_REF, 1'b0, 32'd0,          1'b0, OC_HIT},
    '{ROW_REF, 1'b0, 32'd2,          1'b0, OC_HIT},
    '{ROW_REF, 1'b0, 32'd4,          1'b0, OC_HIT},
    '{ROW_CFG, REG_WAY_COUNT, 32'd9, 1'b0, OC_HIT},
    '{ROW_REF, 1'b0, 32'd1,          1'b0, OC_HIT}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ADDR_W-1:0] in_ref_address = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_outcome;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  set_assoc_cache_miss_classifier_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_ref_address (in_ref_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_outcome    (out_outcome),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk = ~clk;

  // Cache image kept by the testbench.
  logic [CNT_W-1:0]  entry_reg = 10'd512;
  logic [WAYC_W-1:0] way_reg = 4'd4;
  logic [ADDR_W-1:0] line_addr [MAX_ENTRIES];
  bit                line_valid [MAX_ENTRIES];
  int unsigned       next_way [MAX_ENTRIES];
  int unsigned       filled_count;
  int unsigned       geo_sets;
  int unsigned       geo_ways;

  outcome_t expected_outcomes [$];
  outcome_t oldest_outcome;
  int mismatch_count = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  function automatic void clear_cache_image();
    int unsigned e;
    int unsigned w;
    e = entry_reg;
    w = way_reg;
    if (e < 1) e = 1;
    if (e > MAX_ENTRIES) e = MAX_ENTRIES;
    if (w < 1) w = 1;
    if (w > MAX_WAYS) w = MAX_WAYS;
    if (w > e) w = e;
    geo_ways = w;
    geo_sets = e / w;
    filled_count = 0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      line_valid[i] = 1'b0;
      next_way[i] = 0;
    end
  endfunction

  function automatic outcome_t classify_ref(input logic [ADDR_W-1:0] addr);
    int unsigned a;
    int unsigned set_idx;
    int unsigned slot;
    int unsigned w;
    bit was_empty;
    a = addr;
    set_idx = a % geo_sets;
    for (w = 0; w < geo_ways; w++) begin
      slot = set_idx + geo_sets * w;
      if (slot < MAX_ENTRIES && line_valid[slot] && line_addr[slot] == addr) return OC_HIT;
    end
    w = next_way[set_idx] % geo_ways;
    next_way[set_idx] = (w + 1) % geo_ways;
    slot = set_idx + geo_sets * w;
    if (slot >= MAX_ENTRIES) slot = MAX_ENTRIES - 1;
    was_empty = !line_valid[slot];
    if (was_empty) begin
      line_valid[slot] = 1'b1;
      filled_count++;
    end
    line_addr[slot] = addr;
    // A fill that leaves every usable slot valid counts as capacity, even
    // when the slot it went into was empty.
    if (filled_count >= geo_sets * geo_ways) return OC_CAPACITY;
    if (was_empty) return OC_COMPULSORY;
    return OC_CONFLICT;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_ref(input logic [ADDR_W-1:0] addr, input logic typed,
                          input outcome_t want);
    outcome_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ref_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = classify_ref(addr);
    expected_outcomes.push_back(typed ? want : predicted);
  endtask

  task automatic pause_refs();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_outcomes.size() != 0) @(posedge clk);
  endtask

  // Setup and access phase, then wait out the clearing pass that the write starts.
  task automatic write_register(input logic idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_ENTRY_COUNT) entry_reg = value[CNT_W-1:0];
    else way_reg = value[WAYC_W-1:0];
    clear_cache_image();
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_entry_count();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'd1023;
      2: return 32'd512;
      3: return $urandom_range(1023);
      default: return $urandom_range(2, 48);
    endcase
  endfunction

  function automatic logic [31:0] pick_way_count();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'd15;
      2: return $urandom_range(15);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address(input logic [ADDR_W-1:0] base,
                                                      input int unsigned span);
    logic [31:0] raw;
    if ($urandom_range(99) < 8) raw = $urandom;
    else raw = {1'b0, base} + $urandom_range(span);
    return raw[ADDR_W-1:0];
  endfunction

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_outcomes.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing outstanding", out_outcome));
      end else begin
        oldest_outcome = expected_outcomes.pop_front();
        if (out_outcome !== oldest_outcome)
          report_mismatch($sformatf("outcome %0d, expected %0d", out_outcome, oldest_outcome));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [ADDR_W-1:0] base;
    logic [31:0] raw_base;
    int unsigned span;
    int n_refs;
    clear_cache_image();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 17;
    recv_idle_pct = 66;
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_table[r].kind == ROW_CFG) begin
        pause_refs();
        write_register(dir_table[r].reg_idx, dir_table[r].value);
      end else begin
        send_ref(dir_table[r].value[ADDR_W-1:0], dir_table[r].typed, dir_table[r].want);
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      pause_refs();
      send_idle_pct = (mode == 0) ? 17 : (mode == 1) ? 66 : 0;
      recv_idle_pct = (mode == 0) ? 66 : (mode == 1) ? 17 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        pause_refs();
        if ($urandom_range(1)) begin
          write_register(REG_ENTRY_COUNT, pick_entry_count());
          write_register(REG_WAY_COUNT, pick_way_count());
        end else begin
          write_register(REG_WAY_COUNT, pick_way_count());
          write_register(REG_ENTRY_COUNT, pick_entry_count());
        end
        // A narrow address window around a random base gives hits, refills
        // and a full cache; the top bits still vary from segment to segment.
        raw_base = $urandom;
        base = $urandom_range(3) == 0 ? '0 : raw_base[ADDR_W-1:0];
        span = $urandom_range(1, 2 * geo_sets * geo_ways + 2);
        n_refs = $urandom_range(110, 156);
        for (int i = 0; i < n_refs; i++) begin
          if (seg == 1 && i == n_refs / 2) pause_refs();
          send_ref(pick_address(base, span), 1'b0, OC_HIT);
        end
      end
    end

    pause_refs();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_outcomes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
